### design/cfba_pkg.sv
`timescale 1ns / 1ps

package cfba_pkg;

    // Default geometry of the filter bank array.
    localparam int CFBA_BANKS          = 14;
    localparam int CFBA_SLOTS_PER_BANK = 4;

    // Every bank reports four 16-bit filter words, whatever its slot count.
    localparam int CFBA_WORDS    = 4;
    localparam int CFBA_ID_W     = 11;
    localparam int CFBA_WORD_W   = 16;
    localparam int CFBA_ID_SHIFT = 5;
    localparam int CFBA_FILL_W   = 3;
    localparam int CFBA_BANK_W   = 4;
    localparam int CFBA_COUNT_W  = 4;

    // Owner codes of a bank.
    localparam logic [1:0] CFBA_OWNER_NONE = 2'd2;

    // Saturation limit of the assigned-bank counter.
    localparam logic [CFBA_COUNT_W-1:0] CFBA_COUNT_MAX = 4'd15;

    // Result status codes.
    typedef enum logic [1:0] {
        CFBA_ST_OK       = 2'd0,
        CFBA_ST_BAD_FIFO = 2'd1,
        CFBA_ST_FULL     = 2'd2
    } cfba_status_t;

    // Request token that travels down the chain of bank cells, one cell per cycle.
    typedef struct packed {
        logic                                     valid;
        logic                                     found;
        logic                                     bad;
        logic                                     new_bank;
        logic [CFBA_ID_W-1:0]                     ident;
        logic [1:0]                               fifo;
        logic [CFBA_BANK_W-1:0]                   bank;
        logic [CFBA_WORDS-1:0][CFBA_WORD_W-1:0]   words;
    } cfba_token_t;

endpackage

### design/can_filter_bank_allocator.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_ident, s_queue_sel
// m_        out        m_valid, m_ready, m_status, m_bank_index, m_word_a..m_word_d,
//                      m_banks_in_use, m_sticky_flags
//
// A request word is buffered, then its token walks through the chain of bank cells,
// one cell per cycle, and the exiting token sets the result word.
// A new request enters the chain only after the previous token has left it.
// A request word is buffered while a result word waits on m_ready.
// Reset (aresetn low at a rising edge) empties every bank and clears count and flags.
// A stalled result word holds the chain idle; only the input buffer can change meanwhile.

module can_filter_bank_allocator #(
    parameter int BANKS          = cfba_pkg::CFBA_BANKS,
    parameter int SLOTS_PER_BANK = cfba_pkg::CFBA_SLOTS_PER_BANK
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [cfba_pkg::CFBA_ID_W-1:0]   s_ident,
    input  logic [1:0]                       s_queue_sel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [cfba_pkg::CFBA_BANK_W-1:0] m_bank_index,
    output logic [cfba_pkg::CFBA_WORD_W-1:0] m_word_a,
    output logic [cfba_pkg::CFBA_WORD_W-1:0] m_word_b,
    output logic [cfba_pkg::CFBA_WORD_W-1:0] m_word_c,
    output logic [cfba_pkg::CFBA_WORD_W-1:0] m_word_d,
    output logic [cfba_pkg::CFBA_COUNT_W-1:0] m_banks_in_use,
    output logic [1:0]                       m_sticky_flags
);
    import cfba_pkg::*;

    // Input buffer: holds one request word until the chain and the output are free.
    logic                     in_full_reg;
    logic                     in_full_next;
    logic [CFBA_ID_W-1:0]     ident_reg;
    logic [1:0]               queue_reg;

    // Busy is high from launch until the token leaves the last cell.
    logic                     busy_reg;
    logic                     busy_next;
    logic                     launch;

    logic [CFBA_COUNT_W-1:0]  count_reg;
    logic [CFBA_COUNT_W-1:0]  count_next;
    logic [1:0]               flags_reg;
    logic [1:0]               flags_next;

    // Output register.
    logic                     m_valid_reg;
    logic                     m_valid_next;
    cfba_status_t             status_reg;
    cfba_status_t             status_next;
    logic [CFBA_BANK_W-1:0]   bank_reg;
    logic [CFBA_WORDS-1:0][CFBA_WORD_W-1:0] words_reg;

    cfba_token_t              tok [BANKS+1];
    cfba_token_t              exit_tok;
    logic [BANKS-1:0]         chain_valid;

    assign s_ready  = !in_full_reg;
    // The chain holds one token at a time, and the output register is free when it exits.
    assign launch   = in_full_reg && !busy_reg && (!m_valid_reg || m_ready);
    assign exit_tok = tok[BANKS];

    // The token enters the first cell with nothing found and all words zero.
    // A FIFO number above one marks it bad, so no cell takes it.
    always_comb begin
        tok[0]          = '0;
        tok[0].valid    = launch;
        tok[0].bad      = (queue_reg > 2'd1);
        tok[0].ident    = ident_reg;
        tok[0].fifo     = queue_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < BANKS; gi++) begin : g_cell
            cfba_cell #(
                .SLOTS_PER_BANK (SLOTS_PER_BANK),
                .CELL_IDX       (gi)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1])
            );
            assign chain_valid[gi] = tok[gi+1].valid;
        end
    endgenerate

    // Completion: the exiting token decides status, sticky flags and the bank count.
    always_comb begin
        in_full_next = in_full_reg;
        if (s_valid && s_ready) begin
            in_full_next = 1'b1;
        end else if (launch) begin
            in_full_next = 1'b0;
        end

        busy_next = busy_reg;
        if (launch) begin
            busy_next = 1'b1;
        end else if (exit_tok.valid) begin
            busy_next = 1'b0;
        end

        count_next   = count_reg;
        flags_next   = flags_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (exit_tok.valid) begin
            m_valid_next = 1'b1;
            if (exit_tok.bad) begin
                status_next   = CFBA_ST_BAD_FIFO;
                flags_next[0] = 1'b1;
            end else if (!exit_tok.found) begin
                status_next   = CFBA_ST_FULL;
                flags_next[1] = 1'b1;
            end else begin
                status_next = CFBA_ST_OK;
                if (exit_tok.new_bank && (count_reg != CFBA_COUNT_MAX)) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
            status_reg  <= CFBA_ST_OK;
        end else begin
            in_full_reg <= in_full_next;
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ident_reg <= s_ident;
            queue_reg <= s_queue_sel;
        end
        if (exit_tok.valid) begin
            bank_reg  <= exit_tok.bank;
            words_reg <= exit_tok.words;
        end
    end

    // Count and flags are shown as they stand after this word's update; they only
    // change when a token exits, which happens only while the output register is free.
    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_bank_index   = bank_reg;
    assign m_word_a       = words_reg[0];
    assign m_word_b       = words_reg[1];
    assign m_word_c       = words_reg[2];
    assign m_word_d       = words_reg[3];
    assign m_banks_in_use = count_reg;
    assign m_sticky_flags = flags_reg;

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(chain_valid) && (!(|chain_valid) || busy_reg))
        else $error("more than one token in the cell chain");

    a_exit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        exit_tok.valid |-> !m_valid_reg)
        else $error("token exits while a result word is still pending");

    a_flags_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (flags_reg & $past(flags_reg)) == $past(flags_reg))
        else $error("sticky flag cleared");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (status_reg != CFBA_ST_OK)) |->
        (words_reg == '0) && (bank_reg == '0))
        else $error("rejected request carries nonzero bank data");

endmodule

### design/cfba_cell.sv
`timescale 1ns / 1ps

module cfba_cell #(
    parameter int SLOTS_PER_BANK = cfba_pkg::CFBA_SLOTS_PER_BANK,
    parameter int CELL_IDX       = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfba_pkg::cfba_token_t tok_in,
    output cfba_pkg::cfba_token_t tok_out
);
    import cfba_pkg::*;

    logic [1:0]                   owner_reg;
    logic [1:0]                   owner_next;
    logic [CFBA_FILL_W-1:0]       fill_reg;
    logic [CFBA_FILL_W-1:0]       fill_next;
    logic [CFBA_WORD_W-1:0]       words_reg [CFBA_WORDS];
    cfba_token_t                  tok_reg;
    cfba_token_t                  tok_next;
    logic                         hit;
    logic [CFBA_WORD_W-1:0]       new_word;

    // A bank takes the request if it is empty, or owned by the same FIFO with room left.
    always_comb begin
        new_word = {tok_in.ident, {CFBA_ID_SHIFT{1'b0}}};
        hit = tok_in.valid && !tok_in.found && !tok_in.bad &&
              (((owner_reg == tok_in.fifo) &&
                (fill_reg < CFBA_FILL_W'(SLOTS_PER_BANK))) ||
               (fill_reg == '0));
        tok_next   = tok_in;
        owner_next = owner_reg;
        fill_next  = fill_reg;
        if (hit) begin
            owner_next        = tok_in.fifo;
            fill_next         = fill_reg + 1'b1;
            tok_next.found    = 1'b1;
            tok_next.bank     = CFBA_BANK_W'(CELL_IDX);
            tok_next.new_bank = (owner_reg == CFBA_OWNER_NONE);
            for (int k = 0; k < CFBA_WORDS; k++) begin
                if (CFBA_FILL_W'(k) < fill_reg) begin
                    tok_next.words[k] = words_reg[k];
                end else if (CFBA_FILL_W'(k) == fill_reg) begin
                    tok_next.words[k] = new_word;
                end else begin
                    tok_next.words[k] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_reg     <= CFBA_OWNER_NONE;
            fill_reg      <= '0;
            tok_reg.valid <= 1'b0;
        end else begin
            owner_reg <= owner_next;
            fill_reg  <= fill_next;
            tok_reg   <= tok_next;
        end
    end

    // Slot storage needs no reset: only slots below the fill count are ever read.
    always_ff @(posedge aclk) begin
        if (hit) begin
            words_reg[fill_reg[1:0]] <= new_word;
        end
    end

    assign tok_out = tok_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CFBA_FILL_W'(SLOTS_PER_BANK))
        else $error("bank fill count exceeds slot count");

    a_owner_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) == (owner_reg == CFBA_OWNER_NONE))
        else $error("bank owner and fill count disagree");

    a_taken_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_in.valid && tok_in.found) |=> tok_reg.found && $stable(fill_reg))
        else $error("request taken by more than one bank");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cfba_pkg::*;

    // One expected result word, laid out like the result channel of the allocator.
    typedef struct packed {
        cfba_status_t                            status;
        logic [CFBA_BANK_W-1:0]                  bank;
        logic [CFBA_WORDS-1:0][CFBA_WORD_W-1:0]  words;
        logic [CFBA_COUNT_W-1:0]                 in_use;
        logic [1:0]                              flags;
    } alloc_result_t;

    // One request word waiting to be sent. When hold_for_drain is set, the sender
    // waits until every earlier result word has come back before offering it.
    typedef struct packed {
        logic [CFBA_ID_W-1:0] ident;
        logic [1:0]           queue_sel;
        logic                 hold_for_drain;
    } filter_request_t;

    localparam int RANDOM_REQUESTS = 1140;
    localparam int TAIL_CYCLES     = 3 * (CFBA_BANKS + 2);

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [CFBA_ID_W-1:0]      s_ident = '0;
    logic [1:0]                s_queue_sel = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [1:0]                m_status;
    logic [CFBA_BANK_W-1:0]    m_bank_index;
    logic [CFBA_WORD_W-1:0]    m_word_a;
    logic [CFBA_WORD_W-1:0]    m_word_b;
    logic [CFBA_WORD_W-1:0]    m_word_c;
    logic [CFBA_WORD_W-1:0]    m_word_d;
    logic [CFBA_COUNT_W-1:0]   m_banks_in_use;
    logic [1:0]                m_sticky_flags;

    // Requests not yet offered, and result words predicted but not yet received.
    filter_request_t requests_waiting[$];
    alloc_result_t   allocations_due[$];

    // Shadow copy of the bank array, kept in step with every accepted request word.
    logic [1:0]             bank_owner_model[CFBA_BANKS];
    int                     bank_fill_model[CFBA_BANKS];
    logic [CFBA_WORD_W-1:0] bank_ids_model[CFBA_BANKS][CFBA_WORDS];
    logic [CFBA_COUNT_W-1:0] banks_used_model;
    logic [1:0]             sticky_model;

    int            mismatch_count = 0;
    bit            word_in_flight = 1'b0;
    int            send_idle = 0;
    int            recv_idle = 0;
    bit            send_calm = 1'b0;
    bit            recv_calm = 1'b0;
    alloc_result_t arrived_due;
    filter_request_t next_request;

    can_filter_bank_allocator DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ident        (s_ident),
        .s_queue_sel    (s_queue_sel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_bank_index   (m_bank_index),
        .m_word_a       (m_word_a),
        .m_word_b       (m_word_b),
        .m_word_c       (m_word_c),
        .m_word_d       (m_word_d),
        .m_banks_in_use (m_banks_in_use),
        .m_sticky_flags (m_sticky_flags)
    );

    always #2 aclk = ~aclk;

    // Prints one line per wrong or unexpected field and keeps the failure count.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Number of idle cycles before the next word on one side. During a calm
    // stretch the side never idles, so back-to-back traffic is exercised too.
    function automatic int draw_idle(input bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic queue_request(input logic [CFBA_ID_W-1:0] ident, input logic [1:0] sel,
                                 input logic hold);
        filter_request_t req;
        req.ident = ident;
        req.queue_sel = sel;
        req.hold_for_drain = hold;
        requests_waiting.push_back(req);
    endtask

    // First-fit allocation against the shadow banks. A bank qualifies when it
    // already belongs to the requested FIFO and has a free slot, or when it is
    // still empty. The shadow state is updated exactly as the block should update
    // its own, and the result word that the request must produce is returned.
    function automatic alloc_result_t predict_allocation(input logic [CFBA_ID_W-1:0] ident,
                                                         input logic [1:0] fifo);
        alloc_result_t r;
        int hit;
        int i;
        int k;
        logic [CFBA_WORD_W-1:0] shifted;
        r = '0;
        hit = -1;
        if (fifo > 2'd1) begin
            // A FIFO number other than 0 or 1 only raises the sticky invalid flag.
            sticky_model[0] = 1'b1;
            r.status = CFBA_ST_BAD_FIFO;
        end else begin
            for (i = 0; i < CFBA_BANKS && hit < 0; i++) begin
                if ((bank_owner_model[i] == fifo && bank_fill_model[i] < CFBA_SLOTS_PER_BANK)
                    || bank_fill_model[i] == 0) begin
                    hit = i;
                end
            end
            if (hit < 0) begin
                // Every bank is either full or owned by the other FIFO.
                sticky_model[1] = 1'b1;
                r.status = CFBA_ST_FULL;
            end else begin
                if (bank_owner_model[hit] == CFBA_OWNER_NONE && banks_used_model < CFBA_COUNT_MAX) begin
                    banks_used_model++;
                end
                bank_owner_model[hit] = fifo;
                shifted = CFBA_WORD_W'(ident);
                shifted = shifted << CFBA_ID_SHIFT;
                bank_ids_model[hit][bank_fill_model[hit]] = shifted;
                bank_fill_model[hit]++;
                r.status = CFBA_ST_OK;
                r.bank = CFBA_BANK_W'(hit);
                // Slots past the fill level, or past the bank's slot count, read as zero.
                for (k = 0; k < CFBA_WORDS; k++) begin
                    if (k < bank_fill_model[hit] && k < CFBA_SLOTS_PER_BANK) begin
                        r.words[k] = bank_ids_model[hit][k];
                    end
                end
            end
        end
        r.in_use = banks_used_model;
        r.flags = sticky_model;
        return r;
    endfunction

    // Sender. An accepted word is run through the predictor at the edge that
    // accepts it; the next word is then offered after its drawn idle time. The
    // valid line is assigned once per edge, so a word that follows directly keeps
    // valid high without a drop.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < CFBA_BANKS; b++) begin
                bank_owner_model[b] = CFBA_OWNER_NONE;
                bank_fill_model[b] = 0;
            end
            banks_used_model = '0;
            sticky_model = '0;
            word_in_flight = 1'b0;
            send_idle = 0;
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                allocations_due.push_back(predict_allocation(s_ident, s_queue_sel));
                word_in_flight = 1'b0;
            end
            if (!word_in_flight && requests_waiting.size() > 0) begin
                if (send_idle > 0) begin
                    send_idle--;
                end else if (!(requests_waiting[0].hold_for_drain && allocations_due.size() != 0)) begin
                    next_request = requests_waiting.pop_front();
                    s_ident <= next_request.ident;
                    s_queue_sel <= next_request.queue_sel;
                    word_in_flight = 1'b1;
                    if ($urandom_range(0, 39) == 0) begin
                        send_calm = !send_calm;
                    end
                    send_idle = draw_idle(send_calm);
                end
            end
            s_valid <= word_in_flight;
        end
    end

    // Receiver. Every result word is checked against the oldest prediction. After
    // each accepted word a stall is drawn; it only counts down while a result word
    // is actually waiting, so the stall really holds the block back.
    always @(posedge aclk) begin
        if (!aresetn) begin
            recv_idle = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (allocations_due.size() == 0) begin
                    report_mismatch("result word with no request outstanding", m_status, 0);
                end else begin
                    arrived_due = allocations_due.pop_front();
                    if (m_status !== arrived_due.status)
                        report_mismatch("status", m_status, arrived_due.status);
                    if (m_bank_index !== arrived_due.bank)
                        report_mismatch("bank_index", m_bank_index, arrived_due.bank);
                    if (m_word_a !== arrived_due.words[0])
                        report_mismatch("word_a", m_word_a, arrived_due.words[0]);
                    if (m_word_b !== arrived_due.words[1])
                        report_mismatch("word_b", m_word_b, arrived_due.words[1]);
                    if (m_word_c !== arrived_due.words[2])
                        report_mismatch("word_c", m_word_c, arrived_due.words[2]);
                    if (m_word_d !== arrived_due.words[3])
                        report_mismatch("word_d", m_word_d, arrived_due.words[3]);
                    if (m_banks_in_use !== arrived_due.in_use)
                        report_mismatch("banks_in_use", m_banks_in_use, arrived_due.in_use);
                    if (m_sticky_flags !== arrived_due.flags)
                        report_mismatch("sticky_flags", m_sticky_flags, arrived_due.flags);
                end
                if ($urandom_range(0, 39) == 0) begin
                    recv_calm = !recv_calm;
                end
                recv_idle = draw_idle(recv_calm);
            end
            if (recv_idle > 0 && m_valid && !m_ready) begin
                recv_idle--;
            end
            m_ready <= (recv_idle == 0);
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [1:0] run_fifo;
        logic [1:0] sel;
        int run_left;
        int n;

        // Directed words: identifier extremes, both invalid FIFO numbers, a bank
        // filled to its last slot, and a FIFO skipping over a bank that the other
        // FIFO owns. The pattern alternates bits so every identifier bit toggles.
        queue_request(11'h000, 2'd0, 1'b0);
        queue_request(11'h7FF, 2'd2, 1'b0);
        queue_request(11'h7FF, 2'd1, 1'b0);
        queue_request(11'h555, 2'd0, 1'b0);
        queue_request(11'h2AA, 2'd3, 1'b0);
        queue_request(11'h7FF, 2'd0, 1'b0);
        queue_request(11'h001, 2'd0, 1'b0);
        queue_request(11'h400, 2'd0, 1'b0);
        queue_request(11'h3FF, 2'd1, 1'b0);
        queue_request(11'h2AA, 2'd1, 1'b0);
        queue_request(11'h555, 2'd1, 1'b0);
        queue_request(11'h123, 2'd1, 1'b0);
        queue_request(11'h000, 2'd3, 1'b0);
        queue_request(11'h7FE, 2'd0, 1'b0);

        // Random words in runs aimed at one FIFO, so banks of the two FIFOs end up
        // interleaved, with some invalid FIFO numbers mixed in. Once all banks are
        // taken, the banks-full path is exercised for the rest of the run. Some
        // words wait until the block has gone quiet.
        run_left = 0;
        run_fifo = 2'd0;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (run_left == 0) begin
                run_fifo = 2'($urandom_range(0, 1));
                run_left = $urandom_range(1, 6);
            end
            run_left--;
            if ($urandom_range(0, 5) == 0) begin
                sel = 2'($urandom_range(2, 3));
            end else begin
                sel = run_fifo;
            end
            queue_request(CFBA_ID_W'($urandom_range(0, 2047)), sel,
                          n == 0 || n == 30 || n == 600);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (requests_waiting.size() != 0 || word_in_flight || s_valid ||
               allocations_due.size() != 0) begin
            @(posedge aclk);
        end
        // Leave room for any stray result word to show up.
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
